>>> hdl/cfce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_pkg: shared types and constants of the command frame checksum engine
// Word layouts of both channels, function and result codes, controller
// command and datapath status bundles.
// ----------------------------------------------------------------------------
package cfce_pkg;

   // default frame size in bytes
   localparam int FRAME_BYTES_DEF = 64;

   // command codes with special handling
   localparam logic [7:0] CMD_FW_DOWNLOAD = 8'h21;
   localparam logic [7:0] CMD_IR_QUERY    = 8'h18;

   // frame layout
   localparam logic [7:0] REQ_HEAD_BYTES = 8'd4;  // len, mailbox, command, sequence
   localparam logic [7:0] LEN_OFFSET     = 8'd5;  // length byte = payload + 5
   localparam logic [7:0] ACK_HEAD_BYTES = 8'd3;  // len, mailbox, status

   // input function codes
   typedef enum logic [1:0] {
      FUNC_START   = 2'd0,
      FUNC_PAYLOAD = 2'd1,
      FUNC_REPLY   = 2'd2
   } func_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_REPLY = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   // completion status codes
   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_NO_DATA  = 3'd1,
      STAT_BAD_SUM  = 3'd2,
      STAT_DEV_ERR  = 3'd3,
      STAT_TOO_LONG = 3'd4
   } stat_type;

   // transfer phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_RECV = 2'd2
   } phase_type;

   // what the held input word does
   typedef enum logic [2:0] {
      ACT_IGNORE,
      ACT_TOO_LONG,
      ACT_START,
      ACT_PAYLOAD,
      ACT_BODY,
      ACT_FINAL
   } act_type;

   // output word source select
   typedef enum logic [3:0] {
      SEL_LEN,
      SEL_MBOX,
      SEL_CMD,
      SEL_SEQ,
      SEL_ECHO,
      SEL_SUM_HI,
      SEL_SUM_LO,
      SEL_REPLY,
      SEL_DONE
   } sel_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_H_LEN,
      ST_H_MBOX,
      ST_H_CMD,
      ST_H_SEQ,
      ST_ECHO,
      ST_SUM_HI,
      ST_SUM_LO,
      ST_DONE,
      ST_REL_ADDR,
      ST_REL_DATA
   } state_type;

   // request word
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] command;
      logic [7:0] mailbox;
      logic [6:0] write_count;
      logic [6:0] read_count;
      logic [7:0] data_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [2:0] status;
      logic       last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic     take;
      logic     apply;
      logic     load;
      sel_type  sel;
      stat_type stat;
      logic     last;
      logic     rd_en;
      logic     rel_next;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      act_type  act;
      stat_type final_code;
      logic     rlen_zero;
      logic     wzero;
      logic     left_one;
      logic     is_fw;
      logic     slot_free;
      logic     rel_last;
   } dp_stat_type;

endpackage

>>> hdl/cfce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 59
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cfce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_ctrl: sequencing controller
// Takes one request word, has the datapath apply it, then walks out the
// result words one per free output slot, including the reply release.
// ----------------------------------------------------------------------------
module cfce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfce_pkg::dp_stat_type dp_stat,
   output cfce_pkg::ctrl_cmd_type cmd
);
   import cfce_pkg::*;

   state_type state_ff, state_in;
   logic      frame_end_ff, frame_end_in;
   stat_type  done_code_ff, done_code_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_end_ff <= 1'b0;
         done_code_ff <= STAT_OK;
      end else begin
         state_ff     <= state_in;
         frame_end_ff <= frame_end_in;
         done_code_ff <= done_code_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      frame_end_in = frame_end_ff;
      done_code_in = done_code_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.sel      = SEL_DONE;
      cmd.stat     = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.apply    = 1'b1;
            done_code_in = STAT_OK;
            unique case (dp_stat.act)
               ACT_TOO_LONG: begin
                  done_code_in = STAT_TOO_LONG;
                  state_in     = ST_DONE;
               end
               ACT_START: begin
                  frame_end_in = dp_stat.wzero;
                  state_in     = ST_H_LEN;
               end
               ACT_PAYLOAD: begin
                  frame_end_in = dp_stat.left_one;
                  state_in     = ST_ECHO;
               end
               ACT_FINAL: begin
                  done_code_in = dp_stat.final_code;
                  if (dp_stat.final_code == STAT_OK && !dp_stat.rlen_zero) begin
                     state_in = ST_REL_ADDR;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_H_LEN: begin
            cmd.sel = SEL_LEN;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_H_MBOX;
            end
         end
         ST_H_MBOX: begin
            cmd.sel = SEL_MBOX;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_H_CMD;
            end
         end
         ST_H_CMD: begin
            cmd.sel = SEL_CMD;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_H_SEQ;
            end
         end
         ST_H_SEQ, ST_ECHO: begin
            cmd.sel  = (state_ff == ST_H_SEQ) ? SEL_SEQ : SEL_ECHO;
            cmd.last = !frame_end_ff;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = frame_end_ff ? ST_SUM_HI : ST_IDLE;
            end
         end
         ST_SUM_HI: begin
            cmd.sel = SEL_SUM_HI;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_SUM_LO;
            end
         end
         ST_SUM_LO: begin
            // firmware download has no reply: completion follows at once
            cmd.sel  = SEL_SUM_LO;
            cmd.last = !dp_stat.is_fw;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = dp_stat.is_fw ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            cmd.sel  = SEL_DONE;
            cmd.stat = done_code_ff;
            cmd.last = 1'b1;
            if (dp_stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REL_ADDR: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_REL_DATA;
         end
         ST_REL_DATA: begin
            cmd.sel = SEL_REPLY;
            if (dp_stat.slot_free) begin
               cmd.load     = 1'b1;
               cmd.rel_next = 1'b1;
               state_in     = dp_stat.rel_last ? ST_DONE : ST_REL_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> dp_stat.slot_free)
      else $error("result word loaded over an untaken word");

   a_accept_goes_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted word not decoded");

   a_decode_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE) |=> (state_ff != ST_DECODE))
      else $error("decode held for more than one cycle");
`endif

endmodule

>>> hdl/cfce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_datapath: frame state, checksum and output register
// Holds the request word, sequence number, running sum, counters and the
// reply buffer, and builds each result word on command.
// ----------------------------------------------------------------------------
module cfce_datapath #(
   parameter int FRAME_BYTES = cfce_pkg::FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfce_pkg::req_word_type req_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output cfce_pkg::rsp_word_type rsp_data,
   input  cfce_pkg::ctrl_cmd_type cmd,
   output cfce_pkg::dp_stat_type  dp_stat
);
   import cfce_pkg::*;

   localparam int STORE_DEPTH = FRAME_BYTES - 5;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [7:0] WCNT_MAX = 8'(FRAME_BYTES - 6);
   localparam logic [7:0] RCNT_MAX = 8'(FRAME_BYTES - 5);

   req_word_type req_ff, req_in;
   phase_type    phase_ff, phase_in;
   logic [7:0]   seq_ff, seq_in;
   logic [7:0]   hdr_seq_ff, hdr_seq_in;
   logic [7:0]   cmd_ff, cmd_in;
   logic [6:0]   rlen_ff, rlen_in;
   logic [6:0]   left_ff, left_in;
   logic [7:0]   idx_ff, idx_in;
   logic [15:0]  sum_ff, sum_in;
   logic [15:0]  chk_ff, chk_in;
   logic [7:0]   sb_ff, sb_in;
   logic [7:0]   sumh_ff, sumh_in;
   logic [6:0]   rel_idx_ff, rel_idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   act_type      act;
   stat_type     final_code;
   logic         too_long;
   logic [7:0]   body_end;
   logic [15:0]  start_sum;
   logic [15:0]  pay_sum;
   logic [15:0]  fin_sum;
   logic [7:0]   fin_cmd;
   logic         frame_done;
   logic [15:0]  got_sum;
   logic [7:0]   wr_off;
   logic [7:0]   rd_off;
   logic         wr_en;
   logic [7:0]   ram_rd_data;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         seq_ff       <= '0;
         cmd_ff       <= '0;
         rlen_ff      <= '0;
         left_ff      <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         sb_ff        <= '0;
         sumh_ff      <= '0;
         rel_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         cmd_ff       <= cmd_in;
         rlen_ff      <= rlen_in;
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         sb_ff        <= sb_in;
         sumh_ff      <= sumh_in;
         rel_idx_ff   <= rel_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hdr_seq_ff  <= hdr_seq_in;
      chk_ff      <= chk_in;
      rsp_word_ff <= rsp_word_in;
   end

   // classify the held request word against the current phase
   assign too_long = ({1'b0, req_ff.write_count} > WCNT_MAX) ||
                     ({1'b0, req_ff.read_count} > RCNT_MAX);
   assign body_end = {1'b0, rlen_ff} + ACK_HEAD_BYTES;

   always_comb begin
      act = ACT_IGNORE;
      case (req_ff.func)
         FUNC_START:   act = too_long ? ACT_TOO_LONG : ACT_START;
         FUNC_PAYLOAD: act = (phase_ff == PH_SEND) ? ACT_PAYLOAD : ACT_IGNORE;
         FUNC_REPLY: begin
            if (phase_ff != PH_RECV) begin
               act = ACT_IGNORE;
            end else if (idx_ff <= body_end) begin
               act = ACT_BODY;
            end else begin
               act = ACT_FINAL;
            end
         end
         default: act = ACT_IGNORE;
      endcase
   end

   // checksums: odd frame index in the high half
   assign start_sum = {req_ff.mailbox, 8'h00} + {8'h00, req_ff.command} + {seq_ff, 8'h00};
   assign pay_sum   = idx_ff[0] ? sum_ff + {req_ff.data_byte, 8'h00}
                                : sum_ff + {8'h00, req_ff.data_byte};
   assign got_sum   = {sumh_ff, req_ff.data_byte};

   // reply verdict
   always_comb begin
      if (got_sum != ~sum_ff) begin
         final_code = STAT_BAD_SUM;
      end else if (sb_ff != 8'h00) begin
         final_code = (cmd_ff == CMD_IR_QUERY || sb_ff == 8'h01) ? STAT_NO_DATA
                                                                 : STAT_DEV_ERR;
      end else begin
         final_code = STAT_OK;
      end
   end

   assign frame_done = (act == ACT_START && req_ff.write_count == 7'd0) ||
                       (act == ACT_PAYLOAD && left_ff == 7'd1);
   assign fin_sum    = (act == ACT_START) ? start_sum : pay_sum;
   assign fin_cmd    = (act == ACT_START) ? req_ff.command : cmd_ff;

   // state update
   always_comb begin
      req_in     = req_ff;
      phase_in   = phase_ff;
      seq_in     = seq_ff;
      hdr_seq_in = hdr_seq_ff;
      cmd_in     = cmd_ff;
      rlen_in    = rlen_ff;
      left_in    = left_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      chk_in     = chk_ff;
      sb_in      = sb_ff;
      sumh_in    = sumh_ff;
      rel_idx_in = rel_idx_ff;
      wr_en      = 1'b0;
      if (cmd.take) begin
         req_in = req_data;
      end
      if (cmd.apply) begin
         case (act)
            ACT_TOO_LONG: begin
               phase_in = PH_IDLE;
            end
            ACT_START: begin
               seq_in     = seq_ff + 8'd1;
               hdr_seq_in = seq_ff;
               cmd_in     = req_ff.command;
               rlen_in    = req_ff.read_count;
               left_in    = req_ff.write_count;
               idx_in     = REQ_HEAD_BYTES;
               sum_in     = start_sum;
               phase_in   = PH_SEND;
            end
            ACT_PAYLOAD: begin
               idx_in  = idx_ff + 8'd1;
               left_in = left_ff - 7'd1;
               sum_in  = pay_sum;
            end
            ACT_BODY: begin
               if (idx_ff < body_end) begin
                  if (idx_ff != 8'd0) begin
                     sum_in = pay_sum;
                  end
                  if (idx_ff == 8'd2) begin
                     sb_in = req_ff.data_byte;
                  end
                  wr_en = (idx_ff >= ACK_HEAD_BYTES);
               end else begin
                  sumh_in = req_ff.data_byte;
               end
               idx_in = idx_ff + 8'd1;
            end
            ACT_FINAL: begin
               phase_in   = PH_IDLE;
               idx_in     = '0;
               rel_idx_in = '0;
            end
            default: begin
            end
         endcase
         // frame complete: latch the checksum, then wait for a reply unless it is a firmware download
         if (frame_done) begin
            chk_in = ~fin_sum;
            if (fin_cmd == CMD_FW_DOWNLOAD) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_RECV;
               idx_in   = '0;
               sum_in   = '0;
            end
         end
      end
      if (cmd.rel_next) begin
         rel_idx_in = rel_idx_ff + 7'd1;
      end
   end

   // reply buffer
   assign wr_off = idx_ff - ACK_HEAD_BYTES;
   assign rd_off = {1'b0, rel_idx_ff};

   cfce_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_reply_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_off[ADDR_W-1:0]),
      .wr_data (req_ff.data_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_off[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (cmd.load) begin
         rsp_valid_in       = 1'b1;
         rsp_word_in.kind   = KIND_FRAME;
         rsp_word_in.status = STAT_OK;
         rsp_word_in.last   = cmd.last;
         case (cmd.sel)
            SEL_LEN:    rsp_word_in.value = {1'b0, req_ff.write_count} + LEN_OFFSET;
            SEL_MBOX:   rsp_word_in.value = req_ff.mailbox;
            SEL_CMD:    rsp_word_in.value = req_ff.command;
            SEL_SEQ:    rsp_word_in.value = hdr_seq_ff;
            SEL_ECHO:   rsp_word_in.value = req_ff.data_byte;
            SEL_SUM_HI: rsp_word_in.value = chk_ff[15:8];
            SEL_SUM_LO: rsp_word_in.value = chk_ff[7:0];
            SEL_REPLY: begin
               rsp_word_in.kind  = KIND_REPLY;
               rsp_word_in.value = ram_rd_data;
            end
            default: begin
               rsp_word_in.kind   = KIND_DONE;
               rsp_word_in.value  = 8'h00;
               rsp_word_in.status = cmd.stat;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // status to the controller
   always_comb begin
      dp_stat            = '0;
      dp_stat.act        = act;
      dp_stat.final_code = final_code;
      dp_stat.rlen_zero  = (rlen_ff == 7'd0);
      dp_stat.wzero      = (req_ff.write_count == 7'd0);
      dp_stat.left_one   = (left_ff == 7'd1);
      dp_stat.is_fw      = (cmd_ff == CMD_FW_DOWNLOAD);
      dp_stat.slot_free  = !rsp_valid_ff || !rsp_stall;
      dp_stat.rel_last   = ((rel_idx_ff + 7'd1) == rlen_ff);
   end

`ifndef SYNTHESIS
   a_send_has_bytes_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEND) |-> (left_ff != 7'd0))
      else $error("sending phase with no payload bytes left");

   a_release_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (rel_idx_ff < rlen_ff))
      else $error("reply release read past the reply length");
`endif

endmodule

>>> hdl/command_frame_checksum_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_checksum_engine: command frame builder and reply checker
// Builds checksummed request frames, collects reply bytes, verifies the
// reply checksum and releases the reply payload when the reply is good.
// ----------------------------------------------------------------------------
// Each request word is taken in ST_IDLE and decoded in the next cycle; its
// result words then leave one per cycle while the output register is free.
// Reply release reads each payload byte from the registered read port of the
// reply buffer in ST_REL_ADDR and loads it in ST_REL_DATA, then the
// completion word follows.
// Synchronous reset clears the sequence number, phase, counters and sums; the
// reply buffer is not cleared and is always written before it is read.
// ----------------------------------------------------------------------------
module command_frame_checksum_engine #(
   parameter int FRAME_BYTES = cfce_pkg::FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cfce_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cfce_pkg::rsp_word_type rsp_data
);
   import cfce_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  dp_stat;

   // sequencing
   cfce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // frame state and output register
   cfce_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .dp_stat   (dp_stat)
   );

endmodule
